FILE: rtl/aimdcw_pkg.sv
// Package for the AIMD congestion window core: event codes, register map,
// reset values, the config and state structs, min/max and saturating-add helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aimdcw_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned MSS_W = 16;
    localparam int unsigned ADDR_W = 5;

    typedef enum logic [1:0] {
        ACT_INIT    = 2'd0,
        ACT_ACK     = 2'd1,
        ACT_LOSS    = 2'd2,
        ACT_TIMEOUT = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        REG_MSS          = 3'd0,
        REG_WINDOW_LIMIT = 3'd1,
        REG_MIN_WINDOW   = 3'd2,
        REG_INIT_WINDOW  = 3'd3,
        REG_INIT_THRESH  = 3'd4,
        REG_PACING_RATE  = 3'd5
    } t_reg_idx;

    localparam logic [MSS_W-1:0]  RST_MSS          = 16'd1460;
    localparam logic [WORD_W-1:0] RST_WINDOW_LIMIT = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] RST_MIN_WINDOW   = 32'd2920;
    localparam logic [WORD_W-1:0] RST_INIT_WINDOW  = 32'd14600;
    localparam logic [WORD_W-1:0] RST_INIT_THRESH  = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] RST_PACING_RATE  = 32'd0;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic [MSS_W-1:0]  mss;
        logic [WORD_W-1:0] window_limit;
        logic [WORD_W-1:0] min_window;
        logic [WORD_W-1:0] initial_window;
        logic [WORD_W-1:0] initial_threshold;
        logic [WORD_W-1:0] pacing_rate;
    } t_cfg;

    typedef struct packed {
        logic [WORD_W-1:0] cwnd;
        logic [WORD_W-1:0] ssthresh;
        logic [WORD_W-1:0] avoid_accum;
        logic [WORD_W-1:0] floor_window;
    } t_state;

    function automatic logic [WORD_W-1:0] f_umin(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [WORD_W-1:0] f_umax(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [WORD_W-1:0] f_sat_add(input logic [WORD_W-1:0] a,
                                                    input logic [WORD_W-1:0] b);
        logic [WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/aimdcw_if.sv
// Valid/ready channel interfaces for the event and result streams.
// Depends on aimdcw_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface aimdcw_in_if
    import aimdcw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [WORD_W-1:0] bytes_acked;
    logic [WORD_W-1:0] send_window;

    modport source (output valid, action, bytes_acked, send_window, input ready);
    modport sink (input valid, action, bytes_acked, send_window, output ready);
endinterface

interface aimdcw_out_if
    import aimdcw_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              status;
    logic [WORD_W-1:0] cwnd_out;
    logic [WORD_W-1:0] ssthresh_out;
    logic [WORD_W-1:0] pacing_out;

    modport source (output valid, status, cwnd_out, ssthresh_out, pacing_out, input ready);
    modport sink (input valid, status, cwnd_out, ssthresh_out, pacing_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/aimd_congestion_window_core.sv
// Top level of the AIMD congestion window core: input register, window state and update.
// Depends on aimdcw_pkg, aimdcw_if, aimdcw_regs, aimdcw_update and aimdcw_result_reg.
//
//   Channel   Direction  Handshake         Contents
//   i_ev      in         valid/ready       action, bytes_acked, send_window
//   o_res     out        valid/ready       status, cwnd_out, ssthresh_out, pacing_out
//   APB       in/out     psel/penable      six configuration registers on a 32-bit bus
//
// Each event is held in the input register and is then applied to the window
// state in the same cycle as its result is loaded into the result register.
// One event is accepted every cycle unless the output stalls.
// The synchronous reset clears the window state and both stage valid flags.
// A stalled output holds the result register and then the input register; i_ev.ready
// falls only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module aimd_congestion_window_core
    import aimdcw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    aimdcw_in_if.sink              i_ev,
    aimdcw_out_if.source           o_res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0] pwdata,
    output logic      [WORD_W-1:0] prdata,
    output logic                   pready
);

    t_cfg              cfg;
    t_state            r_state;
    t_state            n_state;
    logic              n_status;
    logic              r_in_valid;
    logic [1:0]        r_in_action;
    logic [WORD_W-1:0] r_in_acked;
    logic [WORD_W-1:0] r_in_sendw;
    logic              out_free;
    logic              fire;

    aimdcw_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign fire       = r_in_valid && out_free;
    assign i_ev.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_ev.ready) begin
            r_in_valid <= i_ev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ev.valid && i_ev.ready) begin
            r_in_action <= i_ev.action;
            r_in_acked  <= i_ev.bytes_acked;
            r_in_sendw  <= i_ev.send_window;
        end
    end

    aimdcw_update u_update (
        .i_cfg         (cfg),
        .i_state       (r_state),
        .i_action      (t_action'(r_in_action)),
        .i_bytes_acked (r_in_acked),
        .i_send_window (r_in_sendw),
        .o_state       (n_state),
        .o_status      (n_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    aimdcw_result_reg u_result (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_in_valid),
        .i_status   (n_status),
        .i_cwnd     (n_state.cwnd),
        .i_ssthresh (n_state.ssthresh),
        .i_pacing   (cfg.pacing_rate),
        .o_free     (out_free),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

FILE: rtl/aimdcw_regs.sv
// APB-style configuration register bank of the congestion window core.
// Depends on aimdcw_pkg for the register map, reset values and t_cfg.
`timescale 1ns / 1ps
`default_nettype none

module aimdcw_regs
    import aimdcw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [WORD_W-1:0] pwdata,
    output logic      [WORD_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mss               <= RST_MSS;
            r_cfg.window_limit      <= RST_WINDOW_LIMIT;
            r_cfg.min_window        <= RST_MIN_WINDOW;
            r_cfg.initial_window    <= RST_INIT_WINDOW;
            r_cfg.initial_threshold <= RST_INIT_THRESH;
            r_cfg.pacing_rate       <= RST_PACING_RATE;
        end else if (wr_en) begin
            case (idx)
                REG_MSS:          r_cfg.mss               <= pwdata[MSS_W-1:0];
                REG_WINDOW_LIMIT: r_cfg.window_limit      <= pwdata;
                REG_MIN_WINDOW:   r_cfg.min_window        <= pwdata;
                REG_INIT_WINDOW:  r_cfg.initial_window    <= pwdata;
                REG_INIT_THRESH:  r_cfg.initial_threshold <= pwdata;
                REG_PACING_RATE:  r_cfg.pacing_rate       <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MSS:          prdata = {{(WORD_W-MSS_W){1'b0}}, r_cfg.mss};
            REG_WINDOW_LIMIT: prdata = r_cfg.window_limit;
            REG_MIN_WINDOW:   prdata = r_cfg.min_window;
            REG_INIT_WINDOW:  prdata = r_cfg.initial_window;
            REG_INIT_THRESH:  prdata = r_cfg.initial_threshold;
            REG_PACING_RATE:  prdata = r_cfg.pacing_rate;
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: rtl/aimdcw_update.sv
// Single-pass window update: computes the next window state and status for one event.
// Depends on aimdcw_pkg for t_cfg, t_state, t_action and the saturating helpers.
`timescale 1ns / 1ps
`default_nettype none

module aimdcw_update
    import aimdcw_pkg::*;
(
    input  wire t_cfg              i_cfg,
    input  wire t_state            i_state,
    input  wire t_action           i_action,
    input  wire logic [WORD_W-1:0] i_bytes_acked,
    input  wire logic [WORD_W-1:0] i_send_window,
    output t_state                 o_state,
    output logic                   o_status
);

    logic [WORD_W-1:0] mss_w;
    logic [WORD_W-1:0] dbl_mss;
    logic [WORD_W-1:0] eff_min;
    logic [WORD_W-1:0] cut_ss;
    logic [WORD_W-1:0] ack_cwnd;
    logic [WORD_W-1:0] acc_sum;
    logic              init_bad;

    assign mss_w   = {{(WORD_W-MSS_W){1'b0}}, i_cfg.mss};
    assign dbl_mss = (mss_w > (i_cfg.window_limit >> 1)) ? i_cfg.window_limit
                                                          : {mss_w[WORD_W-2:0], 1'b0};
    assign eff_min = f_umin(f_umax(i_state.floor_window, mss_w), i_cfg.window_limit);
    assign cut_ss  = f_umin(f_umax(f_umin(i_state.cwnd, i_send_window) >> 1, dbl_mss),
                            i_cfg.window_limit);
    assign ack_cwnd = (i_state.cwnd < eff_min) ? eff_min : i_state.cwnd;
    assign acc_sum  = f_sat_add(i_state.avoid_accum, i_bytes_acked);

    assign init_bad = (i_cfg.initial_window < mss_w) ||
                      (i_cfg.min_window < mss_w) ||
                      (i_cfg.initial_window < i_cfg.min_window) ||
                      (i_cfg.initial_threshold < dbl_mss) ||
                      (i_cfg.initial_window > i_cfg.window_limit) ||
                      (i_cfg.initial_threshold > i_cfg.window_limit) ||
                      (i_cfg.min_window > i_cfg.window_limit);

    always_comb begin
        o_state  = i_state;
        o_status = STATUS_OK;
        case (i_action)
            ACT_INIT: begin
                if (init_bad) begin
                    o_status = STATUS_REJECTED;
                end else begin
                    o_state.cwnd         = i_cfg.initial_window;
                    o_state.ssthresh     = i_cfg.initial_threshold;
                    o_state.avoid_accum  = '0;
                    o_state.floor_window = i_cfg.min_window;
                end
            end
            ACT_ACK: begin
                if (ack_cwnd < i_state.ssthresh) begin
                    o_state.cwnd = f_umin(f_sat_add(ack_cwnd, f_umin(i_bytes_acked, dbl_mss)),
                                          i_cfg.window_limit);
                end else if (acc_sum >= ack_cwnd) begin
                    o_state.avoid_accum = acc_sum - ack_cwnd;
                    o_state.cwnd = f_umin(f_sat_add(ack_cwnd, mss_w), i_cfg.window_limit);
                end else begin
                    o_state.avoid_accum = acc_sum;
                    o_state.cwnd        = ack_cwnd;
                end
            end
            ACT_LOSS: begin
                o_state.ssthresh    = cut_ss;
                o_state.cwnd        = f_umin(f_umax(cut_ss, eff_min), i_cfg.window_limit);
                o_state.avoid_accum = '0;
            end
            ACT_TIMEOUT: begin
                o_state.ssthresh    = cut_ss;
                o_state.cwnd        = eff_min;
                o_state.avoid_accum = '0;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/aimdcw_top_note.sv
// Result register stage: holds one finished result and hands it to the output channel.
// Depends on aimdcw_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

module aimdcw_result_reg
    import aimdcw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic              i_status,
    input  wire logic [WORD_W-1:0] i_cwnd,
    input  wire logic [WORD_W-1:0] i_ssthresh,
    input  wire logic [WORD_W-1:0] i_pacing,
    output logic                   o_free,
    aimdcw_out_if.source           o_res
);

    logic              r_valid;
    logic              r_status;
    logic [WORD_W-1:0] r_cwnd;
    logic [WORD_W-1:0] r_ssthresh;
    logic [WORD_W-1:0] r_pacing;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_status   <= i_status;
            r_cwnd     <= i_cwnd;
            r_ssthresh <= i_ssthresh;
            r_pacing   <= i_pacing;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.status       = r_status;
    assign o_res.cwnd_out     = r_cwnd;
    assign o_res.ssthresh_out = r_ssthresh;
    assign o_res.pacing_out   = r_pacing;

endmodule

`default_nettype wire

FILE: sim/aimd_congestion_window_core_test.sv
// Self-checking testbench for aimd_congestion_window_core: directed and random events
// under varying stalls, checked transaction by transaction against a window predictor.
// Depends on aimdcw_pkg, aimdcw_if and the RTL of the core.
`timescale 1ns / 1ps

module aimd_congestion_window_core_test
    import aimdcw_pkg::*;
();

    localparam bit [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        bit        status;
        bit [31:0] cwnd;
        bit [31:0] ssthresh;
        bit [31:0] pacing;
    } t_window_result;

    class t_cwnd_scoreboard;
        bit [15:0] mss;
        bit [31:0] window_limit;
        bit [31:0] min_window;
        bit [31:0] initial_window;
        bit [31:0] initial_threshold;
        bit [31:0] pacing_rate;
        bit [31:0] cwnd;
        bit [31:0] ssthresh;
        bit [31:0] avoid_accum;
        bit [31:0] floor_window;
        t_window_result expected_q[$];
        int errors;

        function new();
            mss = RST_MSS;
            window_limit = RST_WINDOW_LIMIT;
            min_window = RST_MIN_WINDOW;
            initial_window = RST_INIT_WINDOW;
            initial_threshold = RST_INIT_THRESH;
            pacing_rate = RST_PACING_RATE;
            cwnd = 0;
            ssthresh = 0;
            avoid_accum = 0;
            floor_window = 0;
            errors = 0;
        endfunction

        function void write_reg(t_reg_idx idx, bit [31:0] value);
            case (idx)
                REG_MSS:          mss = value[15:0];
                REG_WINDOW_LIMIT: window_limit = value;
                REG_MIN_WINDOW:   min_window = value;
                REG_INIT_WINDOW:  initial_window = value;
                REG_INIT_THRESH:  initial_threshold = value;
                REG_PACING_RATE:  pacing_rate = value;
                default: ;
            endcase
        endfunction

        function bit [31:0] lesser(bit [31:0] a, bit [31:0] b);
            return (a < b) ? a : b;
        endfunction

        function bit [31:0] greater(bit [31:0] a, bit [31:0] b);
            return (a > b) ? a : b;
        endfunction

        function bit [31:0] sat_sum(bit [31:0] v, bit [31:0] inc);
            return (inc > ALL_ONES - v) ? ALL_ONES : v + inc;
        endfunction

        function bit [31:0] capped_sum(bit [31:0] v, bit [31:0] inc);
            return lesser(sat_sum(v, inc), window_limit);
        endfunction

        function bit [31:0] twice_mss();
            return ({16'h0, mss} > window_limit / 2) ? window_limit : {15'h0, mss, 1'b0};
        endfunction

        function bit [31:0] eff_floor();
            return lesser(greater(floor_window, {16'h0, mss}), window_limit);
        endfunction

        function void halve_threshold(bit [31:0] sendw);
            ssthresh = lesser(greater(lesser(cwnd, sendw) >> 1, twice_mss()), window_limit);
        endfunction

        function void note_event(t_action act, bit [31:0] acked, bit [31:0] sendw);
            t_window_result r;
            bit [31:0] lo;
            r.status = STATUS_OK;
            case (act)
                ACT_INIT: begin
                    if (initial_window < mss || min_window < mss ||
                        initial_window < min_window ||
                        initial_threshold < twice_mss() ||
                        initial_window > window_limit ||
                        initial_threshold > window_limit ||
                        min_window > window_limit) begin
                        r.status = STATUS_REJECTED;
                    end else begin
                        cwnd = initial_window;
                        ssthresh = initial_threshold;
                        avoid_accum = 0;
                        floor_window = min_window;
                    end
                end
                ACT_ACK: begin
                    lo = eff_floor();
                    if (cwnd < lo) cwnd = lo;
                    if (cwnd < ssthresh) begin
                        cwnd = capped_sum(cwnd, lesser(acked, twice_mss()));
                    end else begin
                        avoid_accum = sat_sum(avoid_accum, acked);
                        if (avoid_accum >= cwnd) begin
                            avoid_accum = avoid_accum - cwnd;
                            cwnd = capped_sum(cwnd, {16'h0, mss});
                        end
                    end
                end
                ACT_LOSS: begin
                    halve_threshold(sendw);
                    cwnd = lesser(greater(ssthresh, eff_floor()), window_limit);
                    avoid_accum = 0;
                end
                default: begin
                    halve_threshold(sendw);
                    cwnd = eff_floor();
                    avoid_accum = 0;
                end
            endcase
            r.cwnd = cwnd;
            r.ssthresh = ssthresh;
            r.pacing = pacing_rate;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(bit status, bit [31:0] cwnd_got, bit [31:0] ss_got,
                          bit [31:0] pacing_got);
            t_window_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("result transaction with no event pending, cwnd %0d", cwnd_got));
                return;
            end
            want = expected_q.pop_front();
            if (status != want.status)
                report($sformatf("status got %0d, expected %0d", status, want.status));
            if (cwnd_got != want.cwnd)
                report($sformatf("cwnd got %0d, expected %0d", cwnd_got, want.cwnd));
            if (ss_got != want.ssthresh)
                report($sformatf("ssthresh got %0d, expected %0d", ss_got, want.ssthresh));
            if (pacing_got != want.pacing)
                report($sformatf("pacing got %0d, expected %0d", pacing_got, want.pacing));
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [WORD_W-1:0] pwdata;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    aimdcw_in_if  ev_if ();
    aimdcw_out_if res_if ();

    t_cwnd_scoreboard sb;
    int src_idle_pct;
    int sink_idle_pct;
    int stall_cycles = 0;

    aimd_congestion_window_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ev    (ev_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && ev_if.valid && ev_if.ready)
            sb.note_event(t_action'(ev_if.action), ev_if.bytes_acked, ev_if.send_window);
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.status, res_if.cwnd_out, res_if.ssthresh_out,
                            res_if.pacing_out);
    end

    always @(posedge i_clk) begin
        if ((ev_if.valid && ev_if.ready) || (res_if.valid && res_if.ready) ||
            (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("aimd_congestion_window_core_test: errors");
            $finish;
        end
    end

    task automatic send_event(t_action act, bit [31:0] acked, bit [31:0] sendw);
        while ($urandom_range(99) < src_idle_pct) begin
            ev_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        ev_if.valid <= 1'b1;
        ev_if.action <= act;
        ev_if.bytes_acked <= acked;
        ev_if.send_window <= sendw;
        @(posedge i_clk);
        while (!ev_if.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        ev_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(t_reg_idx idx, bit [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic random_config();
        bit [31:0] m;
        bit [31:0] lim;
        bit [31:0] mn;
        bit [31:0] iw;
        bit [31:0] th;
        bit [31:0] pr;
        int r;
        settle();
        r = $urandom_range(99);
        if (r < 10) begin
            m = $urandom;
            lim = $urandom;
            mn = $urandom;
            iw = $urandom;
            th = $urandom;
        end else begin
            m = (r < 16) ? 32'd0 : (r < 22) ? 32'd65535 : $urandom_range(3000, 1);
            mn = $urandom_range(m * 4, m);
            iw = $urandom_range(mn * 8, mn);
            th = (r % 3 == 0) ? ALL_ONES : $urandom_range(iw * 4, m * 2);
            lim = (r < 30) ? ALL_ONES : (r < 36) ? $urandom_range(m * 4, 0) :
                  $urandom_range(th, iw);
            if ($urandom_range(9) == 0) m = m | ($urandom & 32'hFFFF_0000);
        end
        r = $urandom_range(9);
        pr = (r == 0) ? 32'd0 : (r == 1) ? ALL_ONES : $urandom;
        apb_write(REG_MSS, m);
        apb_write(REG_WINDOW_LIMIT, lim);
        apb_write(REG_MIN_WINDOW, mn);
        apb_write(REG_INIT_WINDOW, iw);
        apb_write(REG_INIT_THRESH, th);
        apb_write(REG_PACING_RATE, pr);
    endtask

    task automatic random_event();
        t_action act;
        bit [31:0] acked;
        bit [31:0] sendw;
        int r;
        r = $urandom_range(99);
        act = (r < 6) ? ACT_INIT : (r < 78) ? ACT_ACK : (r < 90) ? ACT_LOSS : ACT_TIMEOUT;
        r = $urandom_range(99);
        acked = (r < 10) ? 32'd0 : (r < 20) ? $urandom : (r < 25) ? ALL_ONES :
                $urandom_range(3 * sb.mss + 1);
        r = $urandom_range(99);
        sendw = (r < 15) ? $urandom : (r < 20) ? 32'd0 : (r < 25) ? ALL_ONES :
                $urandom_range(sb.cwnd);
        if ($urandom_range(99) < 2) drain();
        send_event(act, acked, sendw);
    endtask

    initial begin
        int sent;
        int seg_len;
        sb = new();
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        ev_if.valid = 1'b0;
        ev_if.action = ACT_INIT;
        ev_if.bytes_acked = '0;
        ev_if.send_window = '0;
        res_if.ready = 1'b0;
        src_idle_pct = 12;
        sink_idle_pct = 49;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Events before any init work on the cleared window state.
        send_event(ACT_ACK, 32'd0, 32'd0);
        send_event(ACT_ACK, ALL_ONES, 32'd0);
        send_event(ACT_LOSS, 32'd0, 32'd0);
        send_event(ACT_TIMEOUT, 32'd0, ALL_ONES);
        send_event(ACT_INIT, 32'd0, 32'd0);
        send_event(ACT_ACK, ALL_ONES, 32'd0);
        send_event(ACT_ACK, 32'd1, 32'd0);
        send_event(ACT_LOSS, 32'd0, ALL_ONES);
        send_event(ACT_TIMEOUT, ALL_ONES, 32'd0);

        // All rejection rules but min_window > limit, then an accepted init near a low limit.
        settle();
        apb_write(REG_INIT_WINDOW, 32'd1000);
        send_event(ACT_INIT, 32'd0, 32'd0);
        settle();
        apb_write(REG_INIT_WINDOW, 32'd14600);
        apb_write(REG_MIN_WINDOW, 32'd1000);
        send_event(ACT_INIT, 32'd0, 32'd0);
        settle();
        apb_write(REG_MIN_WINDOW, 32'd20000);
        send_event(ACT_INIT, 32'd0, 32'd0);
        settle();
        apb_write(REG_MIN_WINDOW, 32'd2920);
        apb_write(REG_INIT_THRESH, 32'd2000);
        send_event(ACT_INIT, 32'd0, 32'd0);
        settle();
        apb_write(REG_INIT_THRESH, 32'd15000);
        apb_write(REG_WINDOW_LIMIT, 32'd14000);
        send_event(ACT_INIT, 32'd0, 32'd0);
        settle();
        apb_write(REG_WINDOW_LIMIT, 32'd16000);
        apb_write(REG_INIT_THRESH, 32'd17000);
        send_event(ACT_INIT, 32'd0, 32'd0);
        settle();
        apb_write(REG_INIT_THRESH, 32'd15000);
        apb_write(REG_PACING_RATE, ALL_ONES);
        send_event(ACT_INIT, 32'd0, 32'd0);
        send_event(ACT_ACK, ALL_ONES, 32'd0);
        send_event(ACT_ACK, ALL_ONES, 32'd0);
        send_event(ACT_LOSS, 32'd0, ALL_ONES);

        // A zero segment size from a masked write, with a zero window limit.
        settle();
        apb_write(REG_MSS, 32'h0001_0000);
        apb_write(REG_WINDOW_LIMIT, 32'd0);
        apb_write(REG_MIN_WINDOW, 32'd0);
        apb_write(REG_INIT_WINDOW, 32'd0);
        apb_write(REG_INIT_THRESH, 32'd0);
        apb_write(REG_PACING_RATE, 32'd0);
        send_event(ACT_INIT, 32'd0, 32'd0);
        send_event(ACT_ACK, ALL_ONES, ALL_ONES);
        send_event(ACT_LOSS, ALL_ONES, ALL_ONES);
        send_event(ACT_TIMEOUT, ALL_ONES, ALL_ONES);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 49 : 0;
            sink_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 12 : 0;
            sent = 0;
            while (sent < 300) begin
                random_config();
                seg_len = $urandom_range(60, 20);
                if ($urandom_range(9) != 0) begin
                    send_event(ACT_INIT, $urandom, $urandom);
                    sent++;
                end
                repeat (seg_len) begin
                    random_event();
                    sent++;
                end
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("aimd_congestion_window_core_test: clean");
        end else begin
            $display("aimd_congestion_window_core_test: errors");
        end
        $finish;
    end

endmodule
